FILE: design/rtrlm_pkg.sv
// Shared types, codes and limiter arithmetic for the rule table block.
// No dependencies; used by rule_table_rate_limited_match.
package rtrlm_pkg;

    localparam int RULES_PER_CLASS = 4096;
    localparam int RULE_CLASSES    = 3;
    localparam int ENTRIES         = RULES_PER_CLASS * RULE_CLASSES;
    localparam int AW              = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [15:0] ACT_ALLOW = 16'h0001;
    localparam logic [15:0] ACT_DROP  = 16'h0002;
    localparam logic [15:0] ACT_LOG   = 16'h0004;
    localparam logic [15:0] ACT_RATE  = 16'h0008;
    localparam logic [15:0] ACT_NOOP  = 16'h8000;

    localparam logic [1:0] CLASS_NET  = 2'd0;
    localparam logic [1:0] CLASS_FILE = 2'd1;
    localparam logic [1:0] CLASS_CAN  = 2'd2;

    localparam logic [7:0] FILE_OPS_ALL = 8'd7;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_DEL  = 3'd1,
        CMD_NET  = 3'd2,
        CMD_FILE = 3'd3,
        CMD_CAN  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_BAD_MASK  = 2'd2,
        ST_BAD_OP    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RATE,
        S_LOG
    } state_t;

    // one table entry, held as one memory word
    typedef struct packed {
        logic [15:0] actions;
        logic [2:0]  file_mask;
        logic [31:0] rate_count;
        logic [31:0] rate_start;
        logic [31:0] rate_max;
        logic [15:0] rate_over;
        logic        rate_bytes;
        logic [31:0] log_count;
        logic [31:0] log_start;
        logic [31:0] log_max;
    } entry_t;

    localparam entry_t CLEAR_WORD = '{actions: ACT_ALLOW, default: '0};

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  rule_class;
        logic [15:0] rule_index;
        logic [15:0] action_mask;
        logic [7:0]  file_op_bits;
        logic        rate_kind;
        logic [31:0] rate_limit;
        logic [15:0] over_limit_action;
        logic [31:0] byte_count;
        logic [31:0] now_ticks;
        logic [31:0] now_seconds;
    } item_t;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] start;
        logic [15:0] act;
    } lim_res_t;

    // class addressed by an item: add/delete name it, matches take it from cmd
    function automatic logic [1:0] item_class(logic [2:0] cmd, logic [1:0] rule_class);
        logic [2:0] m;
        m = cmd - CMD_NET;
        return (cmd == CMD_ADD || cmd == CMD_DEL) ? rule_class : m[1:0];
    endfunction

    function automatic logic addr_ok(logic [1:0] cls, logic [15:0] idx);
        return (32'(idx) < RULES_PER_CLASS) && (32'(cls) < RULE_CLASSES);
    endfunction

    function automatic logic [AW-1:0] entry_addr(logic [1:0] cls, logic [15:0] idx);
        return AW'(32'(cls) * RULES_PER_CLASS + 32'(idx));
    endfunction

    // fixed-window limiter, saturating counter
    function automatic lim_res_t limit_step(logic [31:0] count, logic [31:0] start,
                                            logic [31:0] maxv, logic bytes,
                                            logic [15:0] exceed, logic [31:0] now,
                                            logic [31:0] size);
        lim_res_t    r;
        logic [32:0] sum;
        r.count = count;
        r.start = start;
        r.act   = ACT_ALLOW;
        sum     = '0;
        if (now > start)
        begin
            r.count = 32'd1;
            r.start = now;
        end
        else if (!bytes || maxv != 32'd0)
        begin
            sum     = {1'b0, count} + {1'b0, (bytes ? size : 32'd1)};
            r.count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (r.count > maxv)
                r.act = exceed;
        end
        return r;
    endfunction

endpackage

FILE: design/rule_table_rate_limited_match.sv
// Rule table with fixed-window rate and log limiters, one RAM of entries.
// Depends on rtrlm_pkg.
//
//  channel   signals                                   direction
//  item      start, busy, cmd .. now_seconds           in (busy out)
//  result    done, verdict, status                     out, one-cycle strobe
//  config    cfg_we, cfg_data                          in, log_events_per_window
//
// An item goes through RAM read, rate limiter, then log limiter with write-back.
// The result strobe is registered from the write-back state and rises in the cycle after it;
// busy drops then too. After reset a clearing pass writes all ENTRIES words with
// busy high; config writes are taken throughout. Results cannot be stalled.
module rule_table_rate_limited_match (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [1:0]  rule_class,
    input  logic [15:0] rule_index,
    input  logic [15:0] action_mask,
    input  logic [7:0]  file_op_bits,
    input  logic        rate_kind,
    input  logic [31:0] rate_limit,
    input  logic [15:0] over_limit_action,
    input  logic [31:0] byte_count,
    input  logic [31:0] now_ticks,
    input  logic [31:0] now_seconds,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [15:0] verdict,
    output logic [1:0]  status
);

    rtrlm_pkg::state_t  state_reg, state_next;
    logic [rtrlm_pkg::AW-1:0] clr_addr_reg, clr_addr_next;
    logic [31:0]        cfg_reg;
    logic               done_reg;
    logic [15:0]        verdict_out_reg;
    logic [1:0]         status_out_reg;

    rtrlm_pkg::item_t   in_reg;
    logic [rtrlm_pkg::AW-1:0] addr_reg;
    rtrlm_pkg::entry_t  word_reg, word_next;
    logic [15:0]        act_reg, act_next;
    logic [1:0]         status_reg, status_next;
    logic               log_pass_reg, log_pass_next;
    logic               we_reg, we_next;

    rtrlm_pkg::entry_t  mem [rtrlm_pkg::ENTRIES];
    rtrlm_pkg::entry_t  rdata_reg;
    logic               mem_we, mem_re;
    logic [rtrlm_pkg::AW-1:0] mem_waddr, mem_raddr;
    rtrlm_pkg::entry_t  mem_wdata;

    logic               accept;
    logic [1:0]         in_cls;
    logic [1:0]         cls;
    logic               cls_ok;
    rtrlm_pkg::lim_res_t rate_res, log_res;
    rtrlm_pkg::entry_t  word_log;
    logic [15:0]        act_log;

    assign busy    = (state_reg != rtrlm_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign done    = done_reg;
    assign verdict = verdict_out_reg;
    assign status  = status_out_reg;

    assign in_cls    = rtrlm_pkg::item_class(cmd, rule_class);
    assign mem_re    = accept && rtrlm_pkg::addr_ok(in_cls, rule_index);
    assign mem_raddr = rtrlm_pkg::entry_addr(in_cls, rule_index);

    // entry RAM, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // stage one: decode, table updates for add/delete, rate limiter
    always_comb
    begin
        cls           = rtrlm_pkg::item_class(in_reg.cmd, in_reg.rule_class);
        cls_ok        = rtrlm_pkg::addr_ok(cls, in_reg.rule_index);
        word_next     = rdata_reg;
        act_next      = rtrlm_pkg::ACT_NOOP;
        status_next   = rtrlm_pkg::ST_OK;
        log_pass_next = 1'b0;
        we_next       = 1'b0;
        rate_res      = rtrlm_pkg::limit_step(rdata_reg.rate_count, rdata_reg.rate_start,
                            rdata_reg.rate_max, rdata_reg.rate_bytes, rdata_reg.rate_over,
                            (cls == rtrlm_pkg::CLASS_NET) ? in_reg.now_seconds
                                                          : in_reg.now_ticks,
                            (cls == rtrlm_pkg::CLASS_NET) ? in_reg.byte_count : 32'd1);
        case (in_reg.cmd)
            rtrlm_pkg::CMD_ADD, rtrlm_pkg::CMD_DEL:
            begin
                act_next = 16'd0;
                if (!cls_ok)
                    status_next = rtrlm_pkg::ST_BAD_INDEX;
                else
                begin
                    we_next = 1'b1;
                    if (in_reg.cmd == rtrlm_pkg::CMD_DEL)
                    begin
                        word_next.rate_count = '0;
                        word_next.actions    = rtrlm_pkg::ACT_ALLOW;
                    end
                    else
                    begin
                        word_next.actions = in_reg.action_mask;
                        if (cls == rtrlm_pkg::CLASS_FILE
                            && in_reg.file_op_bits > rtrlm_pkg::FILE_OPS_ALL)
                            status_next = rtrlm_pkg::ST_BAD_MASK;
                        else
                        begin
                            if (cls == rtrlm_pkg::CLASS_FILE)
                                word_next.file_mask = in_reg.file_op_bits[2:0];
                            if ((in_reg.action_mask & rtrlm_pkg::ACT_RATE) != 16'd0)
                            begin
                                word_next.rate_count = '0;
                                word_next.rate_max   = in_reg.rate_limit;
                                word_next.rate_over  = in_reg.over_limit_action;
                                word_next.rate_bytes = in_reg.rate_kind;
                            end
                            word_next.log_count = '0;
                            word_next.log_max   = cfg_reg;
                        end
                    end
                end
            end
            rtrlm_pkg::CMD_NET, rtrlm_pkg::CMD_FILE, rtrlm_pkg::CMD_CAN:
            begin
                if (!cls_ok)
                    status_next = rtrlm_pkg::ST_BAD_INDEX;
                else if (cls == rtrlm_pkg::CLASS_FILE && in_reg.file_op_bits[2:0] == 3'd0)
                    status_next = rtrlm_pkg::ST_BAD_OP;
                else if (!(cls == rtrlm_pkg::CLASS_FILE
                           && (rdata_reg.file_mask & in_reg.file_op_bits[2:0]) == 3'd0))
                begin
                    we_next = 1'b1;
                    if ((rdata_reg.actions & rtrlm_pkg::ACT_RATE) != 16'd0)
                    begin
                        act_next             = rate_res.act;
                        word_next.rate_count = rate_res.count;
                        word_next.rate_start = rate_res.start;
                    end
                    else
                        act_next = rdata_reg.actions;
                    log_pass_next = (act_next & (rtrlm_pkg::ACT_LOG | rtrlm_pkg::ACT_DROP))
                                    != 16'd0;
                end
            end
            default:
            begin
                act_next = rtrlm_pkg::ACT_NOOP;
            end
        endcase
    end

    // stage two: log limiter on drop or log verdicts
    always_comb
    begin
        word_log = word_reg;
        act_log  = act_reg;
        log_res  = rtrlm_pkg::limit_step(word_reg.log_count, word_reg.log_start,
                       word_reg.log_max, 1'b0, 16'd0, in_reg.now_seconds, 32'd1);
        if (log_pass_reg)
        begin
            word_log.log_count = log_res.count;
            word_log.log_start = log_res.start;
            if (log_res.act == rtrlm_pkg::ACT_ALLOW)
                act_log = act_reg | rtrlm_pkg::ACT_LOG;
            else
                act_log = act_reg & ~rtrlm_pkg::ACT_LOG;
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = word_log;
        unique case (state_reg)
            rtrlm_pkg::S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = rtrlm_pkg::CLEAR_WORD;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == rtrlm_pkg::AW'(rtrlm_pkg::ENTRIES - 1))
                    state_next = rtrlm_pkg::S_IDLE;
            end
            rtrlm_pkg::S_IDLE:
            begin
                if (start)
                    state_next = rtrlm_pkg::S_RATE;
            end
            rtrlm_pkg::S_RATE:
            begin
                state_next = rtrlm_pkg::S_LOG;
            end
            rtrlm_pkg::S_LOG:
            begin
                mem_we     = we_reg;
                state_next = rtrlm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rtrlm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rtrlm_pkg::S_CLEAR;
            clr_addr_reg <= '0;
            cfg_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= (state_reg == rtrlm_pkg::S_LOG);
            if (cfg_we)
                cfg_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg   <= '{cmd, rule_class, rule_index, action_mask, file_op_bits,
                          rate_kind, rate_limit, over_limit_action, byte_count,
                          now_ticks, now_seconds};
            addr_reg <= mem_raddr;
        end
        if (state_reg == rtrlm_pkg::S_RATE)
        begin
            word_reg     <= word_next;
            act_reg      <= act_next;
            status_reg   <= status_next;
            log_pass_reg <= log_pass_next;
            we_reg       <= we_next;
        end
        if (state_reg == rtrlm_pkg::S_LOG)
        begin
            verdict_out_reg <= act_log;
            status_out_reg  <= status_reg;
        end
    end

    a_done_after_log: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == rtrlm_pkg::S_LOG))
        else $error("result strobe without a write-back cycle");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtrlm_pkg::S_IDLE || state_reg == rtrlm_pkg::S_RATE) |-> !mem_we)
        else $error("RAM written outside clear or write-back");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == rtrlm_pkg::S_RATE)
        else $error("accepted beat did not start the pipeline");

    a_bad_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == rtrlm_pkg::ST_BAD_MASK) |-> verdict == 16'd0)
        else $error("bad file mask must give a zero verdict");

endmodule

FILE: tb/rule_table_match_checker.sv
// Scoreboard for rule_table_rate_limited_match: watches item, config and result channels,
// keeps its own copy of the rule table and limiters and checks every result beat.
// Depends on rtrlm_pkg.
module rule_table_match_checker
    import rtrlm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  item_t       beat,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        done,
    input  logic [15:0] verdict,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending,
    output int          checked,
    output int          limited
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] NO_ACTION = 16'h0000;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] origin;
        logic [15:0] act;
        logic        tripped;
    } window_t;

    typedef struct packed {
        logic [15:0] verdict;
        status_t     status;
    } outcome_t;

    entry_t      rules [ENTRIES];
    logic [31:0] log_quota;
    outcome_t    outcomes_due [$];
    int          mismatches = 0;
    int          seen = 0;
    int          trips = 0;

    // one step of a fixed window; the count sticks at all ones
    function automatic window_t window_step(logic [31:0] count, logic [31:0] origin,
                                            logic [31:0] cap, logic by_bytes,
                                            logic [15:0] exceed, logic [31:0] now,
                                            logic [31:0] amount);
        window_t     w;
        logic [31:0] total;
        w = '{count: count, origin: origin, act: ACT_ALLOW, tripped: 1'b0};
        if (now > origin)
        begin
            w.count  = 32'd1;
            w.origin = now;
        end
        else if (!by_bytes || cap != 32'd0)
        begin
            total   = count + (by_bytes ? amount : 32'd1);
            w.count = (total < count) ? 32'hFFFF_FFFF : total;
            if (w.count > cap)
            begin
                w.act     = exceed;
                w.tripped = 1'b1;
            end
        end
        return w;
    endfunction

    task automatic predict_beat(input item_t it, output outcome_t res);
        logic [1:0]  cls;
        int          e;
        logic [15:0] act;
        logic [31:0] now;
        logic [31:0] amount;
        window_t     w;
        res.verdict = ACT_NOOP;
        res.status  = ST_OK;
        if (it.cmd == CMD_ADD || it.cmd == CMD_DEL)
        begin
            res.verdict = NO_ACTION;
            if (it.rule_index >= RULES_PER_CLASS || it.rule_class >= RULE_CLASSES)
                res.status = ST_BAD_INDEX;
            else
            begin
                e = int'(it.rule_class) * RULES_PER_CLASS + int'(it.rule_index);
                if (it.cmd == CMD_DEL)
                begin
                    rules[e].rate_count = '0;
                    rules[e].actions    = ACT_ALLOW;
                end
                else
                begin
                    rules[e].actions = it.action_mask;
                    if (it.rule_class == CLASS_FILE && it.file_op_bits > FILE_OPS_ALL)
                        res.status = ST_BAD_MASK;
                    else
                    begin
                        if (it.rule_class == CLASS_FILE)
                            rules[e].file_mask = it.file_op_bits[2:0];
                        if ((it.action_mask & ACT_RATE) != 0)
                        begin
                            rules[e].rate_count = '0;
                            rules[e].rate_max   = it.rate_limit;
                            rules[e].rate_over  = it.over_limit_action;
                            rules[e].rate_bytes = it.rate_kind;
                        end
                        // log window re-armed, its start kept
                        rules[e].log_count = '0;
                        rules[e].log_max   = log_quota;
                    end
                end
            end
        end
        else if (it.cmd == CMD_NET || it.cmd == CMD_FILE || it.cmd == CMD_CAN)
        begin
            cls = (it.cmd == CMD_NET) ? CLASS_NET :
                  (it.cmd == CMD_FILE) ? CLASS_FILE : CLASS_CAN;
            if (it.rule_index >= RULES_PER_CLASS)
                res.status = ST_BAD_INDEX;
            else if (cls == CLASS_FILE && (it.file_op_bits & FILE_OPS_ALL) == 0)
                res.status = ST_BAD_OP;
            else
            begin
                e = int'(cls) * RULES_PER_CLASS + int'(it.rule_index);
                if (!(cls == CLASS_FILE && (rules[e].file_mask & it.file_op_bits[2:0]) == 0))
                begin
                    if ((rules[e].actions & ACT_RATE) != 0)
                    begin
                        now    = (cls == CLASS_NET) ? it.now_seconds : it.now_ticks;
                        amount = (cls == CLASS_NET) ? it.byte_count : 32'd1;
                        w = window_step(rules[e].rate_count, rules[e].rate_start,
                                        rules[e].rate_max, rules[e].rate_bytes,
                                        rules[e].rate_over, now, amount);
                        rules[e].rate_count = w.count;
                        rules[e].rate_start = w.origin;
                        act = w.act;
                        if (w.tripped)
                            trips++;
                    end
                    else
                        act = rules[e].actions;
                    // drop or log results go through the log window, always in seconds
                    if ((act & (ACT_LOG | ACT_DROP)) != 0)
                    begin
                        w = window_step(rules[e].log_count, rules[e].log_start,
                                        rules[e].log_max, 1'b0, NO_ACTION,
                                        it.now_seconds, 32'd1);
                        rules[e].log_count = w.count;
                        rules[e].log_start = w.origin;
                        act = (w.act == ACT_ALLOW) ? (act | ACT_LOG) : (act & ~ACT_LOG);
                    end
                    res.verdict = act;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        outcome_t due;
        outcome_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                rules[i]         = '0;
                rules[i].actions = ACT_ALLOW;
            end
            log_quota = '0;
            outcomes_due.delete();
        end
        else
        begin
            if (done)
            begin
                seen++;
                if (outcomes_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: verdict %h status %0d",
                                 $time, verdict, status);
                end
                else
                begin
                    due = outcomes_due.pop_front();
                    if (verdict !== due.verdict || status !== due.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected verdict %h status %0d, got %h %0d",
                                     $time, due.verdict, due.status, verdict, status);
                    end
                end
            end
            if (cfg_we)
                log_quota = cfg_data;
            if (start && !busy)
            begin
                predict_beat(beat, fresh);
                outcomes_due.push_back(fresh);
            end
        end
        fail_count <= mismatches;
        pending    <= outcomes_due.size();
        checked    <= seen;
        limited    <= trips;
    end

endmodule

FILE: tb/rule_table_rate_limited_match_test.sv
// Top of the rule_table_rate_limited_match testbench: clock, reset, directed and random
// beats, log-quota changes between phases, and the verdict.
// Depends on rtrlm_pkg, rule_table_rate_limited_match and rule_table_match_checker.
module rule_table_rate_limited_match_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rtrlm_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 140;

    // codes the package leaves unnamed
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [1:0] CLASS_NONE   = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    item_t       beat = '0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        busy;
    logic        done;
    logic [15:0] verdict;
    logic [1:0]  status;
    int          fail_count;
    int          pending;
    int          checked;
    int          limited;
    int          sent = 0;
    int          cycles = 0;
    bit          gaps_on = 1'b1;
    logic [31:0] secs_now = 32'd1000;
    logic [31:0] ticks_now = 32'd50000;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    rule_table_rate_limited_match dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .cmd               (beat.cmd),
        .rule_class        (beat.rule_class),
        .rule_index        (beat.rule_index),
        .action_mask       (beat.action_mask),
        .file_op_bits      (beat.file_op_bits),
        .rate_kind         (beat.rate_kind),
        .rate_limit        (beat.rate_limit),
        .over_limit_action (beat.over_limit_action),
        .byte_count        (beat.byte_count),
        .now_ticks         (beat.now_ticks),
        .now_seconds       (beat.now_seconds),
        .cfg_we            (cfg_we),
        .cfg_data          (cfg_data),
        .done              (done),
        .verdict           (verdict),
        .status            (status)
    );

    rule_table_match_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .beat       (beat),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .done       (done),
        .verdict    (verdict),
        .status     (status),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .limited    (limited)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic item_t make_beat(logic [2:0] c, logic [1:0] cls, logic [15:0] idx,
                                        logic [15:0] amask, logic [7:0] fops, logic kind,
                                        logic [31:0] lim, logic [15:0] over,
                                        logic [31:0] nbytes, logic [31:0] ticks,
                                        logic [31:0] secs);
        item_t it;
        it.cmd               = c;
        it.rule_class        = cls;
        it.rule_index        = idx;
        it.action_mask       = amask;
        it.file_op_bits      = fops;
        it.rate_kind         = kind;
        it.rate_limit        = lim;
        it.over_limit_action = over;
        it.byte_count        = nbytes;
        it.now_ticks         = ticks;
        it.now_seconds       = secs;
        return it;
    endfunction

    // mostly a few hot rules, so adds and matches meet
    function automatic logic [15:0] pick_index();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
        begin
            case ($urandom_range(4))
                0: return 16'd0;
                1: return 16'd1;
                2: return 16'd2;
                3: return 16'd4094;
                default: return 16'd4095;
            endcase
        end
        else if (roll < 90)
            return 16'($urandom_range(RULES_PER_CLASS - 1));
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // time mostly stands still so windows fill up
    task automatic advance_time();
        int roll;
        roll = $urandom_range(99);
        if (roll >= 96)
        begin
            secs_now  = secs_now - $urandom_range(1, 3);
            ticks_now = ticks_now - $urandom_range(1, 3);
        end
        else if (roll >= 90)
        begin
            secs_now  = $urandom;
            ticks_now = $urandom;
        end
        else if (roll >= 80)
            ticks_now = ticks_now + 1;
        else if (roll >= 70)
            secs_now = secs_now + 1;
    endtask

    // start stays high across back-to-back beats; a gap lowers it first
    task automatic send(input item_t it);
        if (gaps_on && $urandom_range(99) < 26)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        beat  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_log_quota(input logic [31:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // add one rule, then hammer it with matches, mostly in the same window
    task automatic rule_burst();
        logic [1:0]  cls;
        logic [15:0] idx;
        logic [15:0] amask;
        logic        kind;
        logic [31:0] lim;
        logic [7:0]  fops;
        logic [2:0]  mcmd;
        logic [31:0] nbytes;
        int          n;
        cls   = 2'($urandom_range(2));
        idx   = pick_index();
        amask = 16'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < 75)
            amask = amask | ACT_RATE;
        kind = 1'($urandom_range(1));
        if ($urandom_range(9) == 0)
            lim = $urandom;
        else if (kind)
            lim = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(1, 4000));
        else
            lim = 32'($urandom_range(6));
        fops = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 7));
        advance_time();
        send(make_beat(CMD_ADD, cls, idx, amask, fops, kind, lim,
                       16'($urandom_range(16'hFFFF)), $urandom, ticks_now, secs_now));
        mcmd = (cls == CLASS_NET) ? CMD_NET : (cls == CLASS_FILE) ? CMD_FILE : CMD_CAN;
        n = $urandom_range(3, 10);
        repeat (n)
        begin
            advance_time();
            fops   = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(1, 7));
            nbytes = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(1500));
            send(make_beat(mcmd, 2'($urandom_range(3)), idx, 16'($urandom_range(16'hFFFF)),
                           fops, 1'($urandom_range(1)), $urandom,
                           16'($urandom_range(16'hFFFF)), nbytes, ticks_now, secs_now));
        end
        if ($urandom_range(9) == 0)
        begin
            send(make_beat(CMD_DEL, cls, idx, '0, '0, 1'b0, '0, '0, '0, ticks_now, secs_now));
            send(make_beat(mcmd, cls, idx, '0, 8'd7, 1'b0, '0, '0, 32'd64,
                           ticks_now, secs_now));
        end
    endtask

    task automatic stray_beat();
        logic [15:0] idx;
        logic [31:0] ticks;
        logic [31:0] secs;
        idx   = ($urandom_range(1) == 0) ? 16'($urandom_range(16'hFFFF)) : pick_index();
        ticks = ($urandom_range(1) == 0) ? $urandom : ticks_now;
        secs  = ($urandom_range(1) == 0) ? $urandom : secs_now;
        send(make_beat(3'($urandom_range(7)), 2'($urandom_range(3)), idx,
                       16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                       1'($urandom_range(1)), $urandom, 16'($urandom_range(16'hFFFF)),
                       $urandom, ticks, secs));
    endtask

    initial
    begin : stimulus
        int          phase_end;
        logic [31:0] quota;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_log_quota(32'd2);

        // fresh entries, rejected indexes and classes, bad file ops
        send(make_beat(CMD_NET, CLASS_NET, 16'd0, '0, '0, 1'b0, '0, '0, '0, '0, '0));
        send(make_beat(CMD_FILE, CLASS_FILE, 16'd4095, '0, 8'h00, 1'b0, '0, '0, '0, '0, '0));
        send(make_beat(CMD_FILE, CLASS_FILE, 16'd4095, '0, 8'hF8, 1'b0, '0, '0, '0, '0, '0));
        send(make_beat(CMD_CAN, CLASS_CAN, 16'd4096, '0, 8'h01, 1'b0, '0, '0, '0, '0, '0));
        send(make_beat(CMD_NET, CLASS_NET, 16'hFFFF, '0, '0, 1'b0, '0, '0, '0, '0, '0));
        send(make_beat(CMD_ADD, CLASS_NONE, 16'd0, ACT_ALLOW, '0, 1'b0, '0, '0, '0, '0, '0));
        send(make_beat(CMD_DEL, CLASS_NONE, 16'd0, '0, '0, 1'b0, '0, '0, '0, '0, '0));
        send(make_beat(CMD_ADD, CLASS_NET, 16'd4096, ACT_ALLOW, '0, 1'b0, '0, '0, '0, '0, '0));
        // file rule: bad mask on add keeps only the actions, then ops against an empty mask, disjoint ops and a hit
        send(make_beat(CMD_ADD, CLASS_FILE, 16'd5, ACT_ALLOW | ACT_LOG, 8'hFF, 1'b0,
                       '0, '0, '0, '0, '0));
        send(make_beat(CMD_FILE, CLASS_FILE, 16'd5, '0, 8'h01, 1'b0, '0, '0, '0, '0, 32'd5));
        send(make_beat(CMD_ADD, CLASS_FILE, 16'd5, ACT_DROP, 8'h03, 1'b0, '0, '0, '0, '0, '0));
        send(make_beat(CMD_FILE, CLASS_FILE, 16'd5, '0, 8'h04, 1'b0, '0, '0, '0, '0, 32'd10));
        send(make_beat(CMD_FILE, CLASS_FILE, 16'd5, '0, 8'h07, 1'b0, '0, '0, '0, '0, 32'd10));
        // event limiter of 2 in one second: third and later go over, log quota runs out
        send(make_beat(CMD_ADD, CLASS_NET, 16'd4095, ACT_RATE | ACT_ALLOW, '0, 1'b0, 32'd2,
                       ACT_DROP | ACT_LOG, '0, '0, '0));
        repeat (5)
            send(make_beat(CMD_NET, CLASS_NET, 16'd4095, '0, '0, 1'b0, '0, '0, 32'd100,
                           '0, 32'd100));
        // byte limiter with zero cap never trips
        send(make_beat(CMD_ADD, CLASS_CAN, 16'd7, ACT_RATE, '0, 1'b1, 32'd0, ACT_DROP,
                       '0, '0, '0));
        send(make_beat(CMD_CAN, CLASS_CAN, 16'd7, '0, '0, 1'b0, '0, '0, '0, '0, '0));
        // all-ones add, byte counter saturating at the cap
        send(make_beat(CMD_ADD, CLASS_NET, 16'd1, 16'hFFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF,
                       16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        repeat (2)
            send(make_beat(CMD_NET, CLASS_NET, 16'd1, '0, '0, 1'b0, '0, '0, 32'hFFFF_FFFF,
                           '0, '0));
        send(make_beat(CMD_DEL, CLASS_NET, 16'd4095, '0, '0, 1'b0, '0, '0, '0, '0, '0));
        send(make_beat(CMD_NET, CLASS_NET, 16'd4095, '0, '0, 1'b0, '0, '0, 32'd1,
                       '0, 32'd100));
        send(make_beat(CMD_SPARE_LO, CLASS_NET, 16'd0, '0, '0, 1'b0, '0, '0, '0, '0, '0));
        send(make_beat(CMD_SPARE_HI, CLASS_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                       32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(make_beat(CMD_CAN, CLASS_CAN, 16'd4095, '0, '0, 1'b0, '0, '0, '0,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: quota = 32'd0;
                1: quota = 32'd1;
                2: quota = 32'hFFFF_FFFF;
                3: quota = 32'd3;
                default: quota = $urandom;
            endcase
            set_log_quota(quota);
            gaps_on   = (p != 2);  // one phase runs flat out
            phase_end = sent + ITEMS_PER_PHASE;
            while (sent < phase_end)
            begin
                if ($urandom_range(99) < 80)
                    rule_burst();
                else
                    stray_beat();
            end
            drain();
        end
        repeat (6) @(posedge clk);

        $display("Run covered %0d beats over %0d log-quota settings, %0d results checked",
                 sent, PHASES + 1, checked);
        $display("Rate limiter went over its limit %0d times; %0d mismatches",
                 limited, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
